@@ rtl/core/shabs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Request and digest types, queue command format, round constants and
// initial hash values shared by the hasher modules.
// ----------------------------------------------------------------------------
package shabs_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_req_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_rsp_t;

    typedef enum logic [1:0] {
        OP_BYTE     = 2'b01,
        OP_END      = 2'b10,
        OP_BYTE_END = 2'b11
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

    function automatic logic [31:0] init_hash(input logic [2:0] idx);
        logic [31:0] val;
        case (idx)
            3'd0:    val = 32'h6a09e667;
            3'd1:    val = 32'hbb67ae85;
            3'd2:    val = 32'h3c6ef372;
            3'd3:    val = 32'ha54ff53a;
            3'd4:    val = 32'h510e527f;
            3'd5:    val = 32'h9b05688c;
            3'd6:    val = 32'h1f83d9ab;
            default: val = 32'h5be0cd19;
        endcase
        return val;
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] val;
        case (idx)
            6'd0:  val = 32'h428a2f98;
            6'd1:  val = 32'h71374491;
            6'd2:  val = 32'hb5c0fbcf;
            6'd3:  val = 32'he9b5dba5;
            6'd4:  val = 32'h3956c25b;
            6'd5:  val = 32'h59f111f1;
            6'd6:  val = 32'h923f82a4;
            6'd7:  val = 32'hab1c5ed5;
            6'd8:  val = 32'hd807aa98;
            6'd9:  val = 32'h12835b01;
            6'd10: val = 32'h243185be;
            6'd11: val = 32'h550c7dc3;
            6'd12: val = 32'h72be5d74;
            6'd13: val = 32'h80deb1fe;
            6'd14: val = 32'h9bdc06a7;
            6'd15: val = 32'hc19bf174;
            6'd16: val = 32'he49b69c1;
            6'd17: val = 32'hefbe4786;
            6'd18: val = 32'h0fc19dc6;
            6'd19: val = 32'h240ca1cc;
            6'd20: val = 32'h2de92c6f;
            6'd21: val = 32'h4a7484aa;
            6'd22: val = 32'h5cb0a9dc;
            6'd23: val = 32'h76f988da;
            6'd24: val = 32'h983e5152;
            6'd25: val = 32'ha831c66d;
            6'd26: val = 32'hb00327c8;
            6'd27: val = 32'hbf597fc7;
            6'd28: val = 32'hc6e00bf3;
            6'd29: val = 32'hd5a79147;
            6'd30: val = 32'h06ca6351;
            6'd31: val = 32'h14292967;
            6'd32: val = 32'h27b70a85;
            6'd33: val = 32'h2e1b2138;
            6'd34: val = 32'h4d2c6dfc;
            6'd35: val = 32'h53380d13;
            6'd36: val = 32'h650a7354;
            6'd37: val = 32'h766a0abb;
            6'd38: val = 32'h81c2c92e;
            6'd39: val = 32'h92722c85;
            6'd40: val = 32'ha2bfe8a1;
            6'd41: val = 32'ha81a664b;
            6'd42: val = 32'hc24b8b70;
            6'd43: val = 32'hc76c51a3;
            6'd44: val = 32'hd192e819;
            6'd45: val = 32'hd6990624;
            6'd46: val = 32'hf40e3585;
            6'd47: val = 32'h106aa070;
            6'd48: val = 32'h19a4c116;
            6'd49: val = 32'h1e376c08;
            6'd50: val = 32'h2748774c;
            6'd51: val = 32'h34b0bcb5;
            6'd52: val = 32'h391c0cb3;
            6'd53: val = 32'h4ed8aa4a;
            6'd54: val = 32'h5b9cca4f;
            6'd55: val = 32'h682e6ff3;
            6'd56: val = 32'h748f82ee;
            6'd57: val = 32'h78a5636f;
            6'd58: val = 32'h84c87814;
            6'd59: val = 32'h8cc70208;
            6'd60: val = 32'h90befffa;
            6'd61: val = 32'ha4506ceb;
            6'd62: val = 32'hbef9a3f7;
            default: val = 32'hc67178f2;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/shabs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher front end
// Accepts message requests, drops empty ones and turns the rest into queue
// commands (byte, end, or byte with end).
// ----------------------------------------------------------------------------
module shabs_front
(
    input  wire logic               msg_valid,
    output logic                    msg_ready,
    input  wire shabs_pkg::msg_req_t msg_req,
    input  wire logic               queue_full,
    output logic                    push,
    output shabs_pkg::cmd_t         push_cmd
);

    logic useful;

    assign msg_ready = !queue_full;
    assign useful    = msg_req.byte_valid || msg_req.end_of_message;
    assign push      = msg_valid && !queue_full && useful;

    always_comb
    begin
        push_cmd.data_byte = msg_req.data_byte;
        case ({msg_req.byte_valid, msg_req.end_of_message})
            2'b10:   push_cmd.op = shabs_pkg::OP_BYTE;
            2'b01:   push_cmd.op = shabs_pkg::OP_END;
            2'b11:   push_cmd.op = shabs_pkg::OP_BYTE_END;
            default: push_cmd.op = shabs_pkg::OP_BYTE;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/shabs_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher command queue
// Small FIFO between front end and compression core.
// ----------------------------------------------------------------------------
module shabs_queue
#(
    parameter int DEPTH = shabs_pkg::QUEUE_DEPTH
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire shabs_pkg::cmd_t       push_cmd,
    input  wire logic                  pop,
    output logic                       full,
    output shabs_pkg::queue_head_t     head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    shabs_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/shabs_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 hasher compression core
// Gathers bytes into the message schedule window, pads at end of message,
// runs one round per cycle and sends out the eight digest words.
// ----------------------------------------------------------------------------
module shabs_core
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire shabs_pkg::queue_head_t head,
    output logic                        cmd_pop,
    output logic                        digest_valid,
    input  wire logic                   digest_ready,
    output shabs_pkg::digest_rsp_t      digest_rsp
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    state_t      state_reg;
    state_t      state_next;
    logic [5:0]  fill_reg;
    logic [5:0]  fill_next;
    logic [60:0] count_reg;
    logic [60:0] count_next;
    logic [5:0]  round_reg;
    logic [5:0]  round_next;
    logic        pad_reg;
    logic        pad_next;
    logic        pad_first_reg;
    logic        pad_first_next;
    logic        wrap_reg;
    logic        wrap_next;
    logic        final_reg;
    logic        final_next;
    logic [2:0]  out_idx_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] hash_reg [8];

    logic [23:0] acc_reg;
    logic [31:0] win_reg [16];
    logic [31:0] work_reg [8];
    shabs_pkg::digest_rsp_t out_data_reg;

    logic        push_byte;
    logic [7:0]  push_data;
    logic        load_work;
    logic        out_load;
    logic        has_byte;
    logic        has_end;
    logic [63:0] len_bits;
    logic [7:0]  len_byte;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;

    assign has_byte = head.cmd.op inside {shabs_pkg::OP_BYTE, shabs_pkg::OP_BYTE_END};
    assign has_end  = head.cmd.op inside {shabs_pkg::OP_END, shabs_pkg::OP_BYTE_END};
    assign len_bits = {count_reg, 3'b000};
    assign len_byte = 8'(len_bits >> {~fill_reg[2:0], 3'b000});

    assign t1 = work_reg[7] + big_sig1(work_reg[4])
              + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
              + shabs_pkg::round_k(round_reg) + win_reg[0];
    assign t2 = big_sig0(work_reg[0])
              + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                 ^ (work_reg[1] & work_reg[2]));
    assign w_new = sml_sig1(win_reg[14]) + win_reg[9] + sml_sig0(win_reg[1]) + win_reg[0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pad_next       = pad_reg;
        pad_first_next = pad_first_reg;
        wrap_next      = wrap_reg;
        final_next     = final_reg;
        push_byte      = 1'b0;
        push_data      = 8'h00;
        cmd_pop        = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    cmd_pop = 1'b1;
                    if (has_byte)
                    begin
                        push_byte  = 1'b1;
                        push_data  = head.cmd.data_byte;
                        count_next = count_reg + 1'b1;
                    end
                    if (has_end)
                    begin
                        pad_next       = 1'b1;
                        pad_first_next = 1'b1;
                    end
                    if (has_byte && fill_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                    else if (has_end)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_byte      = 1'b1;
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    push_data = shabs_pkg::PAD_BYTE;
                end
                else if (!wrap_reg && fill_reg[5:3] == 3'b111)
                begin
                    push_data = len_byte;
                end
                // 0x80 past byte 55: zero out this block, length goes in the next
                if (pad_first_reg && fill_reg[5:3] == 3'b111)
                begin
                    wrap_next = 1'b1;
                end
                if (fill_reg == 6'd63)
                begin
                    state_next = ST_ROUND;
                    if (!pad_first_reg && !wrap_reg)
                    begin
                        final_next = 1'b1;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                wrap_next = 1'b0;
                if (final_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || digest_ready)
                begin
                    out_load = 1'b1;
                    if (out_idx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        count_next = '0;
                        pad_next   = 1'b0;
                        final_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign fill_next      = push_byte ? fill_reg + 1'b1 : fill_reg;
    assign round_next     = (state_reg == ST_ROUND) ? round_reg + 1'b1 : '0;
    assign load_work      = (state_next == ST_ROUND) && (state_reg != ST_ROUND);
    assign out_valid_next = out_load ? 1'b1 : (digest_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            count_reg     <= '0;
            round_reg     <= '0;
            pad_reg       <= 1'b0;
            pad_first_reg <= 1'b0;
            wrap_reg      <= 1'b0;
            final_reg     <= 1'b0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= shabs_pkg::init_hash(3'(i));
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            round_reg     <= round_next;
            pad_reg       <= pad_next;
            pad_first_reg <= pad_first_next;
            wrap_reg      <= wrap_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                out_idx_reg <= out_idx_reg + 1'b1;
            end
            if (state_reg == ST_ADD)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= hash_reg[i] + work_reg[i];
                end
            end
            else if (out_load && out_idx_reg == 3'd7)
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_reg[i] <= shabs_pkg::init_hash(3'(i));
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_byte)
        begin
            acc_reg <= {acc_reg[15:0], push_data};
            if (fill_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[15] <= {acc_reg, push_data};
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end

        if (load_work)
        begin
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= hash_reg[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            work_reg[0] <= t1 + t2;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= work_reg[1];
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[5] <= work_reg[4];
            work_reg[6] <= work_reg[5];
            work_reg[7] <= work_reg[6];
        end

        if (out_load)
        begin
            out_data_reg.digest_word <= hash_reg[out_idx_reg];
            out_data_reg.word_index  <= out_idx_reg;
            out_data_reg.last_word   <= (out_idx_reg == 3'd7);
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest_rsp   = out_data_reg;

endmodule
`default_nettype wire

@@ rtl/core/sha256_byte_stream_hasher.sv @@
// A data byte enters the schedule window as it leaves the queue; each full
// 64-byte block then runs 64 rounds plus the add, with no new byte taken,
// as the single shared round unit serves every block. End of message: pad
// bytes, one or two compressions, then eight digest words at one per cycle
// while digest_ready allows. Reset restores the initial hash values.
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Front end and command queue feeding a one-round-per-cycle SHA-256 core.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher
#(
    parameter int QUEUE_DEPTH = shabs_pkg::QUEUE_DEPTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   msg_valid,
    output logic                        msg_ready,
    input  wire shabs_pkg::msg_req_t    msg_req,
    output logic                        digest_valid,
    input  wire logic                   digest_ready,
    output shabs_pkg::digest_rsp_t      digest_rsp
);

    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    shabs_pkg::cmd_t        q_cmd;
    shabs_pkg::queue_head_t q_head;

    shabs_front u_front
    (
        .msg_valid  (msg_valid),
        .msg_ready  (msg_ready),
        .msg_req    (msg_req),
        .queue_full (q_full),
        .push       (q_push),
        .push_cmd   (q_cmd)
    );

    shabs_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .full     (q_full),
        .head     (q_head)
    );

    shabs_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .cmd_pop      (q_pop),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_rsp   (digest_rsp)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head.valid)
        else $error("queue pop while empty");

    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_rsp.last_word) |-> (digest_rsp.word_index == 3'd7))
        else $error("last word flag on wrong index");

    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && !digest_rsp.last_word) |=>
        (!digest_valid || digest_rsp.word_index == $past(digest_rsp.word_index) + 3'd1))
        else $error("digest words out of order");
`endif

endmodule
`default_nettype wire

@@ tb/tb_sha256_byte_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher testbench
// Sends byte requests with random gaps and compares every digest word with a
// behavioral SHA-256 predictor. The run covers empty and short messages,
// padding at the block boundaries, and full input stalls.
// ----------------------------------------------------------------------------
module tb_sha256_byte_stream_hasher;

    localparam int REQUEST_TARGET = 310;
    localparam int LONG_HOLD      = 1500;
    localparam int DRAIN_CYCLES   = 300;
    localparam bit [7:0] PAD_START = 8'h80;

    localparam bit [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam bit [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    class digest_scoreboard;
        bit [31:0]   hash_state [8];
        bit [7:0]    block_buf [64];
        int unsigned fill;
        bit [60:0]   byte_count;
        shabs_pkg::digest_rsp_t pending_words [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            hash_state = START_HASH;
            fill       = 0;
            byte_count = '0;
        endfunction

        function bit [31:0] rot_right(bit [31:0] x, int unsigned n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress_block();
            bit [31:0] w [64];
            bit [31:0] a, b, c, d, e, f, g, h;
            bit [31:0] s0, s1, ch, maj, t1, t2;
            int r;
            for (r = 0; r < 16; r++)
            begin
                w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
            end
            for (r = 16; r < 64; r++)
            begin
                s0 = rot_right(w[r-15], 7) ^ rot_right(w[r-15], 18) ^ (w[r-15] >> 3);
                s1 = rot_right(w[r-2], 17) ^ rot_right(w[r-2], 19) ^ (w[r-2] >> 10);
                w[r] = w[r-16] + s0 + w[r-7] + s1;
            end
            a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
            e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
            for (r = 0; r < 64; r++)
            begin
                s1  = rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25);
                ch  = (e & f) ^ (~e & g);
                t1  = h + s1 + ch + ROUND_K[r] + w[r];
                s0  = rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22);
                maj = (a & b) ^ (a & c) ^ (b & c);
                t2  = s0 + maj;
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
            hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
        endfunction

        function void absorb_request(shabs_pkg::msg_req_t req);
            bit [63:0]   bit_len;
            shabs_pkg::digest_rsp_t word;
            int          i;
            if (req.byte_valid)
            begin
                block_buf[fill] = req.data_byte;
                fill = (fill + 1) % 64;
                if (fill == 0)
                    compress_block();
                byte_count = byte_count + 1'b1;
            end
            if (!req.end_of_message)
                return;
            bit_len = {byte_count, 3'b000};
            block_buf[fill] = PAD_START;
            fill++;
            if (fill > 56)
            begin
                while (fill < 64)
                begin
                    block_buf[fill] = 8'h00;
                    fill++;
                end
                compress_block();
                fill = 0;
            end
            while (fill < 56)
            begin
                block_buf[fill] = 8'h00;
                fill++;
            end
            for (i = 0; i < 8; i++)
                block_buf[56+i] = bit_len[63-8*i -: 8];
            compress_block();
            for (i = 0; i < 8; i++)
            begin
                word.digest_word = hash_state[i];
                word.word_index  = i[2:0];
                word.last_word   = (i == 7);
                pending_words.push_back(word);
            end
            restart();
        endfunction

        function void check_digest_word(shabs_pkg::digest_rsp_t got);
            shabs_pkg::digest_rsp_t want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected digest word %h index %0d", $time,
                         got.digest_word, got.word_index);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $display("%0t: digest_word expected %h actual %h", $time,
                         want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_index !== want.word_index)
            begin
                $display("%0t: word_index expected %0d actual %0d", $time,
                         want.word_index, got.word_index);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $display("%0t: last_word expected %b actual %b", $time,
                         want.last_word, got.last_word);
                errors++;
            end
        endfunction

        function int words_outstanding();
            return pending_words.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   msg_valid;
    logic                   msg_ready;
    shabs_pkg::msg_req_t    msg_req;
    logic                   digest_valid;
    logic                   digest_ready;
    shabs_pkg::digest_rsp_t digest_rsp;

    digest_scoreboard sb;
    int requests_sent;

    sha256_byte_stream_hasher i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg_valid    (msg_valid),
        .msg_ready    (msg_ready),
        .msg_req      (msg_req),
        .digest_valid (digest_valid),
        .digest_ready (digest_ready),
        .digest_rsp   (digest_rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("** sha256_byte_stream_hasher: FAILED **");
        $finish;
    end

    function automatic shabs_pkg::msg_req_t make_request(bit [7:0] data, bit valid, bit eom);
        shabs_pkg::msg_req_t req;
        req.data_byte      = data;
        req.byte_valid     = valid;
        req.end_of_message = eom;
        return req;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_request(shabs_pkg::msg_req_t req, int gap);
        if (gap > 0)
        begin
            msg_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        msg_req   <= req;
        msg_valid <= 1'b1;
        do @(posedge clk); while (!msg_ready);
        sb.absorb_request(req);
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(int len);
        bit burst;
        bit end_on_byte;
        int i;
        burst       = ($urandom_range(0, 3) == 0);
        end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b0),
                             burst ? 0 : $urandom_range(0, 16));
            send_request(make_request(8'($urandom_range(0, 255)), 1'b1,
                                      end_on_byte && (i == len - 1)),
                         burst ? 0 : $urandom_range(0, 16));
        end
        if (!end_on_byte)
            send_request(make_request(8'($urandom_range(0, 255)), 1'b0, 1'b1),
                         burst ? 0 : $urandom_range(0, 16));
    endtask

    initial
    begin
        int len;
        sb            = new();
        requests_sent = 0;
        rst_n         = 1'b0;
        msg_valid     = 1'b0;
        msg_req       = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty message, idle request, single bytes at both extremes
        send_request(make_request(8'h00, 1'b0, 1'b1), 0);
        send_request(make_request(8'hff, 1'b0, 1'b0), $urandom_range(0, 16));
        send_request(make_request(8'h00, 1'b1, 1'b1), $urandom_range(0, 16));
        send_request(make_request(8'hff, 1'b1, 1'b1), 0);
        // "abc" closed on the last byte, then closed by a bare end
        send_request(make_request(8'h61, 1'b1, 1'b0), $urandom_range(0, 16));
        send_request(make_request(8'h62, 1'b1, 1'b0), 0);
        send_request(make_request(8'h63, 1'b1, 1'b1), $urandom_range(0, 16));
        send_request(make_request(8'h61, 1'b1, 1'b0), 0);
        send_request(make_request(8'h62, 1'b1, 1'b0), 0);
        send_request(make_request(8'h63, 1'b1, 1'b0), 0);
        send_request(make_request(8'h00, 1'b0, 1'b0), $urandom_range(0, 16));
        send_request(make_request(8'h5a, 1'b0, 1'b1), $urandom_range(0, 16));
        send_request(make_request(8'ha5, 1'b0, 1'b0), 0);
        send_request(make_request(8'h3c, 1'b0, 1'b1), $urandom_range(0, 16));

        msg_valid <= 1'b0;
        while (sb.words_outstanding() != 0)
            @(negedge clk);

        // pad boundaries: one compression, two compressions, full block
        send_message(55);
        send_message(56);
        send_message(64);

        while (requests_sent < REQUEST_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                len = $urandom_range(50, 70);
            else
                len = $urandom_range(0, 12);
            send_message(len);
        end

        msg_valid <= 1'b0;
        while (sb.words_outstanding() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0)
            $display("** sha256_byte_stream_hasher: PASSED **");
        else
            $display("** sha256_byte_stream_hasher: FAILED **");
        $finish;
    end

    initial
    begin
        int gap;
        int words_taken;
        bit burst;
        digest_ready = 1'b0;
        words_taken  = 0;
        burst        = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (words_taken % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            // long hold right after the directed part so the input queue backs up
            if (words_taken == 48)
                gap = LONG_HOLD;
            else
                gap = burst ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                digest_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            digest_ready <= 1'b1;
            do @(posedge clk); while (!digest_valid);
            sb.check_digest_word(digest_rsp);
            words_taken++;
            @(negedge clk);
        end
    end

endmodule

@@ sha256_byte_stream_hasher.f @@
rtl/core/shabs_pkg.sv
rtl/core/shabs_front.sv
rtl/core/shabs_queue.sv
rtl/core/shabs_core.sv
rtl/core/sha256_byte_stream_hasher.sv
tb/tb_sha256_byte_stream_hasher.sv
